[design/hs_pkg.sv]
package hs_pkg;

    localparam int MAX_CHANNELS       = 6;
    localparam int BEAT_WIDTH_DEFAULT = 32;
    localparam int PORT_BEAT_WIDTH    = 32;
    localparam int MISS_WIDTH         = 4;

    localparam logic [MISS_WIDTH-1:0] MISS_LIMIT_RESET = 4'd3;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0] healthy_mask;
        logic                    all_ok;
        logic                    fault_sticky;
    } t_result;

endpackage

[design/hs_lane.sv]
module hs_lane #(
    parameter int BEAT_WIDTH = hs_pkg::BEAT_WIDTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [BEAT_WIDTH-1:0]         i_beat,
    input  logic [hs_pkg::MISS_WIDTH-1:0] i_miss_limit,
    output logic                          o_ok_next
);

    logic [BEAT_WIDTH-1:0]         r_last;
    logic [hs_pkg::MISS_WIDTH-1:0] r_miss;
    logic                          r_seen;
    logic                          r_ok;

    logic [BEAT_WIDTH-1:0]         n_last;
    logic [hs_pkg::MISS_WIDTH-1:0] n_miss;
    logic                          n_ok;

    always_comb begin
        n_last = r_last;
        n_miss = r_miss;
        n_ok   = r_ok;
        if (!r_seen || (i_beat != r_last)) begin
            n_last = i_beat;
            n_miss = '0;
            n_ok   = 1'b1;
        end else begin
            if (r_miss < i_miss_limit) begin
                n_miss = r_miss + 1'b1;
            end
            if (n_miss >= i_miss_limit) begin
                n_ok = 1'b0;
            end
        end
    end

    assign o_ok_next = n_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= '0;
            r_seen <= 1'b0;
            r_ok   <= 1'b1;
        end else if (i_accept) begin
            r_miss <= n_miss;
            r_seen <= 1'b1;
            r_ok   <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_last <= n_last;
        end
    end

`ifndef SYNTH
    a_unseen_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_ok && (r_miss == '0)))
        else $error("lane not seen yet but carries miss state");

    a_fall_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ok) |-> $past(i_accept))
        else $error("lane health dropped without an accepted beat");
`endif

endmodule

[design/hs_merge.sv]
module hs_merge #(
    parameter int CHANNELS = hs_pkg::MAX_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [hs_pkg::MAX_CHANNELS-1:0] i_ok_next,
    input  logic                            i_out_stall,
    output logic                            o_skid_full,
    output logic                            o_out_valid,
    output hs_pkg::t_result                 o_result
);

    logic            r_fault;
    logic            r_out_v;
    logic            r_skid_v;
    hs_pkg::t_result r_out;
    hs_pkg::t_result r_skid;

    logic            n_all;
    logic            n_fault;
    hs_pkg::t_result n_res;
    logic            out_free;

    assign n_all   = &i_ok_next[CHANNELS-1:0];
    assign n_fault = r_fault | ~n_all;

    always_comb begin
        n_res              = '0;
        n_res.healthy_mask = i_ok_next;
        n_res.all_ok       = n_all;
        n_res.fault_sticky = n_fault;
    end

    assign out_free = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault  <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (i_accept) begin
                r_fault <= n_fault;
            end
            if (out_free) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= i_accept;
                end
            end else if (i_accept) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (i_accept) begin
                r_out <= n_res;
            end
        end else if (i_accept) begin
            r_skid <= n_res;
        end
    end

    assign o_skid_full = r_skid_v;
    assign o_out_valid = r_out_v;
    assign o_result    = r_out;

`ifndef SYNTH
    a_fault_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("fault latch cleared without reset");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while output stage is empty");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_out_stall && !r_skid_v && !i_accept) |=> !r_out_v)
        else $error("output stays valid after its beat was taken");
`endif

endmodule

[design/heartbeat_supervisor.sv]
// Heartbeat supervisor.
// Input channel: one beat per supervision tick, carrying the heartbeat counter
// of every monitored channel (i_beat_ch0..i_beat_ch5), qualified by i_in_valid
// and taken at a clock edge where o_in_stall is low.
// Output channel: one beat per tick with the healthy mask, the all-healthy flag,
// the sticky fault and the watchdog kick, qualified by o_out_valid and taken
// when i_out_stall is low.
// One lane per channel compares and counts in parallel and the merge stage
// registers the result, so a new tick is taken every cycle while o_in_stall is
// low.
// When the receiver stalls, the held result stays put and one more tick goes
// into a skid register; o_in_stall rises only when that skid register is full.
// The user must write the miss limit through i_cfg_we/i_cfg_wdata only while
// the block is idle; the block does not enforce this. Synchronous reset clears
// all lanes (unseen, healthy), the fault latch and both output regs; limit = 3.
module heartbeat_supervisor #(
    parameter int CHANNELS   = hs_pkg::MAX_CHANNELS,
    parameter int BEAT_WIDTH = hs_pkg::BEAT_WIDTH_DEFAULT
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [hs_pkg::MISS_WIDTH-1:0]            i_cfg_wdata,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic [hs_pkg::PORT_BEAT_WIDTH-1:0]       i_beat_ch0,
    input  logic [hs_pkg::PORT_BEAT_WIDTH-1:0]       i_beat_ch1,
    input  logic [hs_pkg::PORT_BEAT_WIDTH-1:0]       i_beat_ch2,
    input  logic [hs_pkg::PORT_BEAT_WIDTH-1:0]       i_beat_ch3,
    input  logic [hs_pkg::PORT_BEAT_WIDTH-1:0]       i_beat_ch4,
    input  logic [hs_pkg::PORT_BEAT_WIDTH-1:0]       i_beat_ch5,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [hs_pkg::MAX_CHANNELS-1:0]          o_healthy_mask,
    output logic                                     o_all_ok,
    output logic                                     o_fault_sticky,
    output logic                                     o_kick
);

    localparam int EXT_WIDTH = (BEAT_WIDTH > hs_pkg::PORT_BEAT_WIDTH) ?
                               BEAT_WIDTH : hs_pkg::PORT_BEAT_WIDTH;

    logic [hs_pkg::MISS_WIDTH-1:0]      r_miss_limit;
    logic [hs_pkg::PORT_BEAT_WIDTH-1:0] beats [hs_pkg::MAX_CHANNELS];
    logic [hs_pkg::MAX_CHANNELS-1:0]    ok_next;
    logic                               skid_full;
    logic                               accept;
    hs_pkg::t_result                    result;

    assign beats[0] = i_beat_ch0;
    assign beats[1] = i_beat_ch1;
    assign beats[2] = i_beat_ch2;
    assign beats[3] = i_beat_ch3;
    assign beats[4] = i_beat_ch4;
    assign beats[5] = i_beat_ch5;

    assign accept     = i_in_valid && !skid_full;
    assign o_in_stall = skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_limit <= hs_pkg::MISS_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_miss_limit <= i_cfg_wdata;
        end
    end

    for (genvar g = 0; g < hs_pkg::MAX_CHANNELS; g++) begin : g_lane
        if (g < CHANNELS) begin : g_on
            logic [EXT_WIDTH-1:0] beat_ext;

            assign beat_ext = EXT_WIDTH'(beats[g]);

            hs_lane #(
                .BEAT_WIDTH (BEAT_WIDTH)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_accept     (accept),
                .i_beat       (beat_ext[BEAT_WIDTH-1:0]),
                .i_miss_limit (r_miss_limit),
                .o_ok_next    (ok_next[g])
            );
        end else begin : g_off
            assign ok_next[g] = 1'b0;
        end
    end

    hs_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_ok_next   (ok_next),
        .i_out_stall (i_out_stall),
        .o_skid_full (skid_full),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_healthy_mask = result.healthy_mask;
    assign o_all_ok       = result.all_ok;
    assign o_fault_sticky = result.fault_sticky;
    assign o_kick         = ~result.fault_sticky;

endmodule
